// File: sv/ppc_pkg.sv
package ppc_pkg;

  localparam int unsigned PiQ    = 205887;
  localparam int unsigned TwoPiQ = 411775;

  localparam logic [15:0] DeadbandRst   = 16'd655;
  localparam logic [15:0] GainTransRst  = 16'd256;
  localparam logic [15:0] GainRotRst    = 16'd256;
  localparam logic [30:0] LimitRotRst   = 31'd32768;
  localparam logic [30:0] LimitTransRst = 31'd32768;

  typedef enum logic [1:0] {
    OP_ABS  = 2'd0,
    OP_REL  = 2'd1,
    OP_ODOM = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_DEADBAND    = 3'd0,
    REG_GAIN_TRANS  = 3'd1,
    REG_GAIN_ROT    = 3'd2,
    REG_LIMIT_ROT   = 3'd3,
    REG_LIMIT_TRANS = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_GAIN,
    ST_MAG,
    ST_CHK,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_OUT
  } state_t;

  // Operation request to the shared divider / square-root unit.
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;
    logic [31:0] den;
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } iter_rsp_t;

  // Wrap steps: bounded repeats of the 2 pi correction, one per cycle.
  function automatic logic signed [33:0] wrap_step(input logic signed [33:0] a);
    logic signed [33:0] r;
    r = a;
    if (a > $signed(34'(PiQ)))
      r = a - $signed(34'(TwoPiQ));
    else if (a < -$signed(34'(PiQ)))
      r = a + $signed(34'(TwoPiQ));
    return r;
  endfunction

endpackage

// File: sv/ppc_iter.sv
// Shared bit-serial unit: restoring divide (64 by 32) or integer square root of 64 bits.
module ppc_iter
  import ppc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        sq_r, sq_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] num_r, num_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [64:0] rem_sh;
  logic [64:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sq_nxt   = sq_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    rem_sh   = '0;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      sq_nxt   = req.is_sqrt;
      cnt_nxt  = '0;
      num_nxt  = req.num;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (sq_r) begin
        // Two bits of the radicand per step, one root bit out.
        rem_sh = {rem_r[62:0], num_r[63:62]};
        trial  = {quo_r[62:0], 2'b01};
        num_nxt = {num_r[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        if (cnt_r == 6'd31) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        rem_sh  = {rem_r[63:0], num_r[63]};
        trial   = {33'd0, den_r};
        num_nxt = {num_r[62:0], 1'b0};
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        if (cnt_r == 6'd63) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
      cnt_nxt = cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sq_r  <= sq_nxt;
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = quo_r;

endmodule

// File: sv/planar_pose_p_controller_unit.sv
// Proportional pose controller for a planar robot base, Q16.16 fixed point.
// Input channel (in_*): one transfer carries an operation in in_tuser
// (absolute setpoint, relative setpoint or odometry sample) and the x, y and
// heading values in in_tdata. Setpoint transfers update the stored target and
// clear the reached flag; they produce no result. An odometry transfer
// produces one result on the out_* channel (velocity commands in out_tdata,
// reached flag in out_tuser) unless the target was already reached.
// Configuration (cfg_*): index 0 deadband, 1 translational gain, 2 rotational
// gain, 3 rotational limit, 4 translational limit; they are to be written only
// while idle, which the block does not enforce. One item is worked at a time.
// A setpoint passes the wrap state, staying there while its heading still
// needs a 2 pi correction. An odometry item passes the wrap, gain, magnitude
// and check states to the output state; when the vector must be scaled, the
// shared bit-serial unit works in between (32 square-root steps, then two
// 64-step divides). The next transfer is taken once the block is idle again.
// An odometry sample after the target was reached, or an unused operation, is dropped.
// After a synchronous reset the target is zero, reached is clear and the
// registers hold their defaults. A result waits in the output register while
// the receiver stalls; the next item is still taken and worked, and holds
// in its last step until the output register is free.
module planar_pose_p_controller_unit
  import ppc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // value_x[31:0], value_y[63:32], value_angle[83:64]
  input  logic [1:0]   in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // cmd_x[31:0], cmd_y[63:32], cmd_angle[95:64]
  output logic         out_tuser,  // reached
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  state_t state_r, state_nxt;
  logic [15:0] deadband_r, gain_trans_r, gain_rot_r;
  logic [30:0] limit_rot_r, limit_trans_r;
  logic signed [31:0] tx_r, ty_r, th_r;
  logic goal_done_r;

  logic [1:0] op_r;
  logic signed [31:0] vx_r, vy_r;
  logic signed [33:0] ang_r, ang_nxt;
  logic signed [31:0] cx_r, cy_r, ca_r;
  logic [63:0] m2_r;
  logic [31:0] root_r;
  logic out_valid_r;
  logic [95:0] out_data_r;
  logic out_user_r;
  logic out_load;

  iter_req_t req;
  iter_rsp_t rsp;

  ppc_iter u_iter (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The finished command goes out once the output register is free.
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Gain path: deadband, magnitude times gain, shift by 8, sign restore.
  function automatic logic signed [63:0] gained(input logic signed [33:0] e,
                                                 input logic [15:0] g,
                                                 input logic [15:0] db);
    logic [33:0] m;
    logic [49:0] p;
    logic signed [63:0] r;
    m = e[33] ? 34'(-e) : 34'(e);
    p = 50'(m) * 50'(g);
    r = $signed(64'(p >> 8));
    if (m < 34'(db)) r = '0;
    else if (e[33]) r = -r;
    return r;
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
    return v > S32Max ? S32Max : (v < S32Min ? S32Min : v);
  endfunction

  logic signed [33:0] ex, ey;
  logic signed [63:0] gx, gy, ga, lr;
  logic [31:0] cxm, cym;
  logic [63:0] sqx, sqy, limsq;
  assign ex  = 34'(tx_r) - 34'(vx_r);
  assign ey  = 34'(ty_r) - 34'(vy_r);
  assign gx  = gained(ex, gain_trans_r, deadband_r);
  assign gy  = gained(ey, gain_trans_r, deadband_r);
  assign ga  = gained(ang_r, gain_rot_r, deadband_r);
  assign lr  = $signed({33'd0, limit_rot_r});
  // The commands are clamped to plus/minus (2^31 - 1), so the magnitude fits.
  assign cxm = cx_r[31] ? 32'(-cx_r) : 32'(cx_r);
  assign cym = cy_r[31] ? 32'(-cy_r) : 32'(cy_r);
  assign sqx = 64'(cxm) * 64'(cxm);
  assign sqy = 64'(cym) * 64'(cym);
  assign limsq = 64'(limit_trans_r) * 64'(limit_trans_r);
  assign ang_nxt = wrap_step(ang_r);

  logic [63:0] pnum;
  assign pnum = 64'(state_r == ST_SQRT ? cxm : cym) * 64'(limit_trans_r);

  always_comb begin
    state_nxt = state_r;
    req = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready &&
            !(in_tuser == OP_NONE || (in_tuser == OP_ODOM && goal_done_r)))
          state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        if (ang_nxt == ang_r) begin
          if (op_r == OP_ODOM) state_nxt = ST_GAIN;
          else state_nxt = ST_IDLE;
        end
      end
      ST_GAIN: state_nxt = ST_MAG;
      ST_MAG: state_nxt = ST_CHK;
      ST_CHK: begin
        if (m2_r > limsq) begin
          req.start = 1'b1;
          req.is_sqrt = 1'b1;
          req.num = m2_r;
          state_nxt = ST_SQRT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SQRT: if (rsp.done) state_nxt = ST_DIVX;
      ST_DIVX: if (rsp.done) state_nxt = ST_DIVY;
      ST_DIVY: if (rsp.done) state_nxt = ST_OUT;
      ST_OUT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_SQRT && rsp.done) begin
      req.start = 1'b1;
      req.num = pnum;
      req.den = rsp.result[31:0];
    end
    if (state_r == ST_DIVX && rsp.done) begin
      req.start = 1'b1;
      req.num = pnum;
      req.den = root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      deadband_r <= DeadbandRst;
      gain_trans_r <= GainTransRst;
      gain_rot_r <= GainRotRst;
      limit_rot_r <= LimitRotRst;
      limit_trans_r <= LimitTransRst;
      tx_r <= '0;
      ty_r <= '0;
      th_r <= '0;
      goal_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_DEADBAND:    deadband_r <= cfg_data[15:0];
          REG_GAIN_TRANS:  gain_trans_r <= cfg_data[15:0];
          REG_GAIN_ROT:    gain_rot_r <= cfg_data[15:0];
          REG_LIMIT_ROT:   limit_rot_r <= cfg_data[30:0];
          REG_LIMIT_TRANS: limit_trans_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tuser;
            vx_r <= in_tdata[31:0];
            vy_r <= in_tdata[63:32];
            case (op_t'(in_tuser))
              OP_ABS: begin
                tx_r <= in_tdata[31:0];
                ty_r <= in_tdata[63:32];
                ang_r <= 34'($signed(in_tdata[83:64]));
                goal_done_r <= 1'b0;
              end
              OP_REL: begin
                tx_r <= 32'(clamp(64'(tx_r) + 64'($signed(in_tdata[31:0]))));
                ty_r <= 32'(clamp(64'(ty_r) + 64'($signed(in_tdata[63:32]))));
                ang_r <= 34'(th_r) + 34'($signed(in_tdata[83:64]));
                goal_done_r <= 1'b0;
              end
              OP_ODOM: ang_r <= 34'(th_r) - 34'($signed(in_tdata[83:64]));
              default: ang_r <= '0;
            endcase
          end
        end
        ST_WRAP: begin
          ang_r <= ang_nxt;
          if (ang_nxt == ang_r && op_r != OP_ODOM) th_r <= 32'(ang_r);
        end
        ST_GAIN: begin
          cx_r <= 32'(clamp(gx < -S32Max ? -S32Max : gx));
          cy_r <= 32'(clamp(gy < -S32Max ? -S32Max : gy));
          ca_r <= 32'(ga > lr ? lr : (ga < -lr ? -lr : ga));
        end
        ST_MAG: m2_r <= sqx + sqy;
        ST_SQRT: if (rsp.done) root_r <= rsp.result[31:0];
        ST_DIVX: if (rsp.done) cx_r <= cx_r[31] ? -rsp.result[31:0] : rsp.result[31:0];
        ST_DIVY: if (rsp.done) cy_r <= cy_r[31] ? -rsp.result[31:0] : rsp.result[31:0];
        ST_OUT: begin
          if (out_load) begin
            out_data_r <= {ca_r, cy_r, cx_r};
            out_user_r <= (cx_r == 0) && (cy_r == 0) && (ca_r == 0);
            if ((cx_r == 0) && (cy_r == 0) && (ca_r == 0)) goal_done_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: bench/pose_cmd_checker.sv
`timescale 1ns / 100ps

// Watches the command and configuration channels of the pose controller,
// predicts each velocity command and compares it with what comes out.
module pose_cmd_checker
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] ca;
    logic        hit;
  } vel_cmd_t;

  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;

  vel_cmd_t cmd_q[$];
  logic [15:0] dband, kt, kr;
  logic [30:0] lim_r, lim_t;
  longint goal_x, goal_y, goal_th;
  logic goal_hit;

  assign pending = cmd_q.size();

  function automatic longint wrap_pi(longint a);
    while (a > longint'(PiQ) || a < -longint'(PiQ)) begin
      if (a < 0) a += longint'(TwoPiQ);
      else a -= longint'(TwoPiQ);
    end
    return a;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint apply_gain(longint e, logic [15:0] k);
    longint m;
    longint p;
    m = e < 0 ? -e : e;
    if (m < longint'(dband)) return 0;
    p = (m * longint'(k)) >>> 8;
    return e < 0 ? -p : p;
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint rescale(longint v, longint unsigned l, longint unsigned m);
    longint unsigned q;
    q = (longint'(v < 0 ? -v : v) * l) / m;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic predict(input logic [1:0] op, input logic [87:0] d);
    longint vx, vy, va, cx, cy, ca;
    longint unsigned m2, l;
    vel_cmd_t c;
    vx = longint'($signed(d[31:0]));
    vy = longint'($signed(d[63:32]));
    va = longint'($signed(d[83:64]));
    if (op == OP_ABS) begin
      goal_x = vx; goal_y = vy; goal_th = wrap_pi(va); goal_hit = 0;
    end else if (op == OP_REL) begin
      goal_x = sat(goal_x + vx, SatMin, SatMax);
      goal_y = sat(goal_y + vy, SatMin, SatMax);
      goal_th = wrap_pi(goal_th + va);
      goal_hit = 0;
    end else if (op == OP_ODOM && !goal_hit) begin
      cx = sat(apply_gain(goal_x - vx, kt), -SatMax, SatMax);
      cy = sat(apply_gain(goal_y - vy, kt), -SatMax, SatMax);
      ca = apply_gain(wrap_pi(goal_th - va), kr);
      ca = sat(ca, -longint'(lim_r), longint'(lim_r));
      l = lim_t;
      m2 = longint'(cx * cx) + longint'(cy * cy);
      if (m2 > l * l) begin
        cx = rescale(cx, l, root_floor(m2));
        cy = rescale(cy, l, root_floor(m2));
      end
      c.cx = cx[31:0]; c.cy = cy[31:0]; c.ca = ca[31:0];
      c.hit = (cx == 0 && cy == 0 && ca == 0);
      if (c.hit) goal_hit = 1;
      cmd_q.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    vel_cmd_t w;
    if (!rst_n) begin
      dband <= DeadbandRst; kt <= GainTransRst; kr <= GainRotRst;
      lim_r <= LimitRotRst; lim_t <= LimitTransRst;
      goal_x = 0; goal_y = 0; goal_th = 0; goal_hit = 0;
      cmd_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_DEADBAND:    dband <= cfg_data[15:0];
          REG_GAIN_TRANS:  kt <= cfg_data[15:0];
          REG_GAIN_ROT:    kr <= cfg_data[15:0];
          REG_LIMIT_ROT:   lim_r <= cfg_data[30:0];
          REG_LIMIT_TRANS: lim_t <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (cmd_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          w = cmd_q.pop_front();
          if (out_tdata[31:0] !== w.cx)
            report($sformatf("cmd_x %h, expected %h", out_tdata[31:0], w.cx));
          if (out_tdata[63:32] !== w.cy)
            report($sformatf("cmd_y %h, expected %h", out_tdata[63:32], w.cy));
          if (out_tdata[95:64] !== w.ca)
            report($sformatf("cmd_angle %h, expected %h", out_tdata[95:64], w.ca));
          if (out_tuser !== w.hit)
            report($sformatf("reached %b, expected %b", out_tuser, w.hit));
        end
      end
      if (in_tvalid && in_tready) predict(in_tuser, in_tdata);
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the pose controller. The checker beside the block
// predicts and compares; this module only makes transfers and decides.
module testbench;
  import ppc_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0] in_tuser = OP_ABS;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_DEADBAND;
  logic [31:0] cfg_data = '0;
  int errors;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;

  always #1 clk = ~clk;

  planar_pose_p_controller_unit uut (.*);
  pose_cmd_checker chk (.*);

  // The receiver stalls at random, with a percentage set per phase.
  always @(negedge clk) out_tready <= rst_n && ($urandom_range(99) >= recv_idle);

  // One transfer on the input channel; valid is dropped only when the
  // sender decides to idle, so back-to-back transfers keep it high.
  task automatic send(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                      input logic [19:0] a);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tuser <= op;
    in_tdata <= {4'b0, a, y, x};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only with nothing in flight; the pause covers the
  // slowest scaled odometry item plus any heading wrap.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [19:0] rand_angle();
    return 20'($signed($urandom_range(823550)) - 411775);
  endfunction

  // Values are mostly near the target so that deadband, clamp and reached
  // all occur; some are wide to reach saturation and vector scaling.
  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  task automatic random_items(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: send(OP_ABS, rand_pos(), rand_pos(), rand_angle());
        1: send(OP_REL, rand_pos(), rand_pos(), rand_angle());
        2: send(OP_NONE, $urandom, $urandom, 20'($urandom));
        default: send(OP_ODOM, rand_pos(), rand_pos(), rand_angle());
      endcase
    end
  endtask

  task automatic random_config();
    write_reg(REG_DEADBAND, $urandom_range(3) == 0 ? 32'hFFFF : $urandom_range(3000));
    write_reg(REG_GAIN_TRANS, $urandom_range(3) == 0 ? 32'hFFFF : $urandom_range(1024));
    write_reg(REG_GAIN_ROT, $urandom_range(3) == 0 ? 32'hFFFF : $urandom_range(1024));
    write_reg(REG_LIMIT_ROT, $urandom_range(3) == 0 ? 32'h7FFFFFFF : $urandom_range(200000));
    write_reg(REG_LIMIT_TRANS, $urandom_range(3) == 0 ? 32'h7FFFFFFF : $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed part at reset settings: extremes, wraps, saturation, reached.
    send(OP_ODOM, 32'd0, 32'd0, 20'd0);
    send(OP_ODOM, 32'd0, 32'd0, 20'd0);
    send(OP_ABS, 32'h7FFFFFFF, 32'h80000000, 20'd411775);
    send(OP_ODOM, 32'h80000000, 32'h7FFFFFFF, -20'sd411775);
    send(OP_REL, 32'h7FFFFFFF, 32'h80000000, 20'd411775);
    send(OP_ODOM, 32'd100, 32'hFFFFFF00, 20'd205887);
    send(OP_REL, 32'h80000000, 32'h7FFFFFFF, -20'sd411775);
    send(OP_ODOM, 32'd654, 32'd655, 20'd1);
    send(OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'hFFFFF);
    send(OP_ABS, 32'd0, 32'd0, 20'd0);
    send(OP_ODOM, 32'd10, 32'd0, 20'd0);
    send(OP_ODOM, 32'd0, 32'd0, 20'd0);
    send(OP_ABS, 32'd300000, 32'd400000, 20'd205888);
    send(OP_ODOM, 32'd0, 32'd0, -20'sd205888);

    write_reg(REG_DEADBAND, 32'd0);
    write_reg(REG_GAIN_TRANS, 32'hFFFF);
    write_reg(REG_GAIN_ROT, 32'hFFFF);
    write_reg(REG_LIMIT_ROT, 32'h7FFFFFFF);
    write_reg(REG_LIMIT_TRANS, 32'h7FFFFFFF);
    send(OP_ABS, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'd205887);
    send(OP_ODOM, 32'h80000000, 32'h80000000, -20'sd205887);
    send(OP_ODOM, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'd205887);

    write_reg(REG_DEADBAND, 32'hFFFF);
    write_reg(REG_GAIN_TRANS, 32'd0);
    write_reg(REG_GAIN_ROT, 32'd0);
    write_reg(REG_LIMIT_ROT, 32'd0);
    write_reg(REG_LIMIT_TRANS, 32'd0);
    send(OP_ABS, 32'd5000000, 32'd0, 20'd0);
    send(OP_ODOM, 32'd0, 32'd0, 20'd100000);

    // Three idling phases, each under a few random settings.
    send_idle = 23; recv_idle = 74;
    repeat (3) begin random_config(); random_items(85); end
    send_idle = 74; recv_idle = 23;
    repeat (3) begin random_config(); random_items(85); end
    send_idle = 0; recv_idle = 0;
    repeat (3) begin random_config(); random_items(85); end

    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
